FILE: rtl/srl_pkg.sv
// Shared types, constants and helpers of the source rate limiter.
package srl_pkg;

    localparam int TableEntries = 64;
    localparam int IdxW         = $clog2(TableEntries);
    localparam int CntW         = $clog2(TableEntries + 1);
    localparam int QueueDepth   = 2;

    typedef enum logic [2:0] {
        FN_CONNECT = 3'd0,
        FN_AUTHQ   = 3'd1,
        FN_AFAIL   = 3'd2,
        FN_AOK     = 3'd3,
        FN_BLOCK   = 3'd4,
        FN_UNBLOCK = 3'd5,
        FN_SWEEP   = 3'd6,
        FN_QUERY   = 3'd7
    } t_func;

    localparam logic [2:0] RegMaxConn = 3'd0;
    localparam logic [2:0] RegMaxAtt  = 3'd1;
    localparam logic [2:0] RegMaxFail = 3'd2;
    localparam logic [2:0] RegBlkMin  = 3'd3;
    localparam logic [2:0] RegProg    = 3'd4;

    // Input beat after the front end has decoded it.
    typedef struct packed {
        t_func        func;
        logic [31:0]  addr;
        logic [31:0]  now;
        logic [15:0]  admin;
    } t_event;

    // One table record.
    typedef struct packed {
        logic [31:0] addr;
        logic [9:0]  active;
        logic [9:0]  attempts;
        logic [7:0]  failures;
        logic        blocked;
        logic [31:0] wstart;
        logic [31:0] bend;
    } t_rec;

    typedef struct packed {
        logic [9:0]  max_conn;
        logic [9:0]  max_att;
        logic [7:0]  max_fail;
        logic [10:0] blk_min;
        logic        prog;
    } t_cfg;

    typedef struct packed {
        logic        allowed;
        logic        blocked_now;
        logic [7:0]  fail_cnt;
        logic [9:0]  active_count;
        logic        table_full;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SEARCH,
        ST_READ,
        ST_CALC,
        ST_MULT,
        ST_WRITE,
        ST_OUT
    } t_state;

    // Tier multiplier of the block length.
    function automatic logic [4:0] tier_mult(input logic [7:0] f);
        logic [4:0] m;
        if (f <= 8'd5)       m = 5'd1;
        else if (f <= 8'd10) m = 5'd2;
        else if (f <= 8'd15) m = 5'd5;
        else if (f <= 8'd20) m = 5'd10;
        else                 m = 5'd30;
        return m;
    endfunction

endpackage

FILE: rtl/srl_front.sv
// Front end: input beat capture, config registers and event queue.
module srl_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [79:0]           s_axis_tdata,
    input  logic [2:0]            s_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output srl_pkg::t_cfg         o_cfg,
    output logic                  o_ev_valid,
    input  logic                  i_ev_ready,
    output srl_pkg::t_event       o_ev
);

    srl_pkg::t_event q_mem [srl_pkg::QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    srl_pkg::t_cfg r_cfg;
    srl_pkg::t_event w_in;
    logic w_push, w_pop;

    assign w_in.func  = srl_pkg::t_func'(s_axis_tuser);
    assign w_in.addr  = s_axis_tdata[31:0];
    assign w_in.now   = s_axis_tdata[63:32];
    assign w_in.admin = s_axis_tdata[79:64];

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push = s_axis_tvalid && s_axis_tready;
    assign o_ev_valid = (r_cnt != 2'd0);
    assign w_pop = o_ev_valid && i_ev_ready;
    assign o_ev = q_mem[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) q_mem[r_wp] <= w_in;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_conn <= 10'd10;
            r_cfg.max_att  <= 10'd10;
            r_cfg.max_fail <= 8'd5;
            r_cfg.blk_min  <= 11'd15;
            r_cfg.prog     <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                srl_pkg::RegMaxConn: r_cfg.max_conn <= pwdata[9:0];
                srl_pkg::RegMaxAtt:  r_cfg.max_att  <= pwdata[9:0];
                srl_pkg::RegMaxFail: r_cfg.max_fail <= pwdata[7:0];
                srl_pkg::RegBlkMin:  r_cfg.blk_min  <= pwdata[10:0];
                srl_pkg::RegProg:    r_cfg.prog     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            srl_pkg::RegMaxConn: prdata = {22'd0, r_cfg.max_conn};
            srl_pkg::RegMaxAtt:  prdata = {22'd0, r_cfg.max_att};
            srl_pkg::RegMaxFail: prdata = {24'd0, r_cfg.max_fail};
            srl_pkg::RegBlkMin:  prdata = {21'd0, r_cfg.blk_min};
            srl_pkg::RegProg:    prdata = {31'd0, r_cfg.prog};
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/srl_back.sv
// Back end: table memory, search, record update and result register.
module srl_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  srl_pkg::t_cfg         i_cfg,
    input  logic                  i_ev_valid,
    output logic                  o_ev_ready,
    input  srl_pkg::t_event       i_ev,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output srl_pkg::t_result      o_res
);

    localparam int IW = srl_pkg::IdxW;
    localparam int CW = srl_pkg::CntW;

    srl_pkg::t_rec mem [srl_pkg::TableEntries];
    logic [srl_pkg::TableEntries-1:0] r_valid;

    srl_pkg::t_state r_st, n_st;
    srl_pkg::t_event r_ev;
    logic [CW-1:0] r_ptr;
    srl_pkg::t_rec r_rd;
    logic [IW-1:0] r_hit_idx, r_free_idx;
    logic r_hit, r_free;
    srl_pkg::t_rec r_rec;
    logic r_allowed;
    logic [42:0] r_min;  // block minutes before the *60
    logic r_setend;
    srl_pkg::t_result r_res;
    logic r_out_v;
    logic r_cmp_v;
    logic [IW-1:0] r_cmp_idx;

    logic [IW-1:0] w_idx;
    logic w_done;
    logic w_keep;
    logic w_full;
    logic [IW-1:0] w_widx;

    assign w_idx  = r_ptr[IW-1:0];
    assign w_done = (r_ptr == CW'(srl_pkg::TableEntries));
    assign w_keep = r_hit || (r_free && (r_ev.func <= srl_pkg::FN_BLOCK));
    assign w_full = !r_hit && !r_free && (r_ev.func <= srl_pkg::FN_BLOCK);
    assign w_widx = r_hit ? r_hit_idx : r_free_idx;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= srl_pkg::ST_IDLE;
        else          r_st <= n_st;
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            srl_pkg::ST_IDLE:
                if (i_ev_valid && !r_out_v)
                    n_st = (i_ev.func == srl_pkg::FN_SWEEP) ? srl_pkg::ST_SWEEP
                                                            : srl_pkg::ST_SEARCH;
            srl_pkg::ST_SWEEP:  if (w_done) n_st = srl_pkg::ST_SEARCH;
            srl_pkg::ST_SEARCH: if (w_done) n_st = srl_pkg::ST_READ;
            srl_pkg::ST_READ:   n_st = srl_pkg::ST_CALC;
            srl_pkg::ST_CALC:   n_st = srl_pkg::ST_MULT;
            srl_pkg::ST_MULT:   n_st = srl_pkg::ST_WRITE;
            srl_pkg::ST_WRITE:  n_st = srl_pkg::ST_OUT;
            srl_pkg::ST_OUT:    n_st = srl_pkg::ST_IDLE;
            default:            n_st = srl_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ev_ready = (r_st == srl_pkg::ST_IDLE) && !r_out_v;
    end

    // memory read; sweep uses a two-phase pipeline: read at ptr, write back at ptr-1
    logic r_sw_v;
    logic [IW-1:0] r_sw_idx;

    always_ff @(posedge i_clk) begin
        if (r_st == srl_pkg::ST_READ)
            r_rd <= mem[w_widx];
        else if (!w_done)
            r_rd <= mem[w_idx];
    end

    // sweep entry update
    srl_pkg::t_rec w_sw;
    always_comb begin
        w_sw = r_rd;
        if (r_rd.blocked && r_ev.now >= r_rd.bend) begin
            w_sw.blocked = 1'b0;
            w_sw.bend    = '0;
        end
        if (r_ev.now >= r_rd.wstart && (r_ev.now - r_rd.wstart) > 32'd120) begin
            w_sw.attempts = '0;
            w_sw.wstart   = r_ev.now;
        end
    end

    // record update, first step
    srl_pkg::t_rec w_base, w_new;
    logic w_allow, w_set;
    logic [42:0] w_m;
    always_comb begin
        w_base = r_hit ? r_rd : '0;
        w_base.addr = r_ev.addr;
        w_new = w_base;
        w_allow = 1'b0;
        w_set = 1'b0;
        w_m = '0;
        unique case (r_ev.func)
            srl_pkg::FN_CONNECT: begin
                if (!(w_new.blocked && r_ev.now < w_new.bend)) begin
                    if (w_new.blocked) begin
                        w_new.blocked = 1'b0; w_new.bend = '0;
                    end
                    if (w_new.active < i_cfg.max_conn) begin
                        if (r_ev.now >= w_new.wstart &&
                            (r_ev.now - w_new.wstart) >= 32'd60) begin
                            w_new.attempts = '0; w_new.wstart = r_ev.now;
                        end
                        if (w_new.attempts < i_cfg.max_att) begin
                            if (w_new.active != 10'h3FF)
                                w_new.active = w_new.active + 10'd1;
                            if (w_new.attempts != 10'h3FF)
                                w_new.attempts = w_new.attempts + 10'd1;
                            w_allow = 1'b1;
                        end
                    end
                end
            end
            srl_pkg::FN_AUTHQ:
                w_allow = !(w_new.blocked && r_ev.now < w_new.bend);
            srl_pkg::FN_AFAIL: begin
                if (w_new.failures != 8'hFF)
                    w_new.failures = w_new.failures + 8'd1;
                if (w_new.failures >= i_cfg.max_fail) begin
                    w_new.blocked = 1'b1;
                    w_set = 1'b1;
                    w_m = i_cfg.prog
                        ? 43'({11'd0, i_cfg.blk_min} *
                              {11'd0, srl_pkg::tier_mult(w_new.failures)})
                        : 43'(i_cfg.blk_min);
                end
            end
            srl_pkg::FN_AOK: w_new.failures = '0;
            srl_pkg::FN_BLOCK: begin
                w_new.blocked = 1'b1;
                w_set = 1'b1;
                w_m = (r_ev.admin != 16'd0) ? 43'(r_ev.admin) : 43'(i_cfg.blk_min);
            end
            srl_pkg::FN_UNBLOCK:
                if (r_hit) begin
                    w_new.blocked = 1'b0; w_new.bend = '0; w_new.failures = '0;
                end
            default: ;
        endcase
    end

    // block end: now + minutes*60, saturated
    logic [43:0] w_end;
    assign w_end = 44'(r_ev.now) + 44'(r_min * 43'd60);

    // main datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            srl_pkg::ST_IDLE: begin
                r_ev <= i_ev;
                r_ptr <= '0;
                r_hit <= 1'b0;
                r_free <= 1'b0;
                r_sw_v <= 1'b0;
                r_cmp_v <= 1'b0;
            end
            srl_pkg::ST_SWEEP: begin
                r_sw_v <= !w_done;
                r_sw_idx <= w_idx;
                r_cmp_v <= 1'b0;
                if (w_done) r_ptr <= '0;
                else        r_ptr <= r_ptr + CW'(1);
            end
            srl_pkg::ST_SEARCH: begin
                r_sw_v <= 1'b0;
                // compare the entry read last cycle
                r_cmp_v <= !w_done;
                r_cmp_idx <= w_idx;
                if (r_cmp_v) begin
                    if (r_valid[r_cmp_idx] && !r_hit && (r_rd.addr == r_ev.addr)) begin
                        r_hit <= 1'b1; r_hit_idx <= r_cmp_idx;
                    end
                    if (!r_valid[r_cmp_idx] && !r_free) begin
                        r_free <= 1'b1; r_free_idx <= r_cmp_idx;
                    end
                end
                if (!w_done) r_ptr <= r_ptr + CW'(1);
            end
            srl_pkg::ST_CALC: begin
                r_rec <= w_new;
                r_allowed <= w_allow;
                r_setend <= w_set;
                r_min <= w_m;
            end
            srl_pkg::ST_MULT:
                if (r_setend)
                    r_rec.bend <= w_end[43:32] != 12'd0 ? 32'hFFFF_FFFF : w_end[31:0];
            default: ;
        endcase
    end

    // record writes
    always_ff @(posedge i_clk) begin
        if (r_st == srl_pkg::ST_WRITE && w_keep) begin
            mem[w_widx] <= r_rec;
        end else if (r_sw_v && r_valid[r_sw_idx]) begin
            mem[r_sw_idx] <= w_sw;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= '0;
        else if (r_st == srl_pkg::ST_WRITE && w_keep) r_valid[w_widx] <= 1'b1;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (r_st == srl_pkg::ST_OUT) r_out_v <= 1'b1;
        else if (i_res_ready) r_out_v <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == srl_pkg::ST_OUT) begin
            r_res.allowed       <= r_allowed;
            r_res.blocked_now   <= r_rec.blocked && (r_ev.now < r_rec.bend);
            r_res.fail_cnt      <= r_rec.failures;
            r_res.active_count  <= r_rec.active;
            r_res.table_full    <= w_full;
        end
    end

    assign o_res_valid = r_out_v;
    assign o_res = r_res;

endmodule

FILE: rtl/source_rate_limiter_blocker.sv
// Top level of the per-source connection rate limiter and blocker.
// The back end handles one beat at a time, scanning the table one entry per cycle;
// a sweep adds a pass of its own, and the next beat waits for an empty result register.
// A two-entry queue takes beats while the scan runs; the result register holds
// one finished beat. Reset (synchronous, active low) clears all valid bits and
// restores register defaults; no clearing pass is needed.
module source_rate_limiter_blocker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // source_addr, now_seconds, admin_minutes
    input  logic [2:0]  s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // allowed, blocked_now, failure count,
                                       // active_count, table_full, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    srl_pkg::t_cfg    w_cfg;
    srl_pkg::t_event  w_ev;
    srl_pkg::t_result w_res;
    logic w_ev_v, w_ev_r;

    assign pready = 1'b1;

    srl_front u_front (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .o_cfg(w_cfg), .o_ev_valid(w_ev_v), .i_ev_ready(w_ev_r), .o_ev(w_ev)
    );

    srl_back u_back (
        .i_clk, .i_rst_n, .i_cfg(w_cfg), .i_ev_valid(w_ev_v),
        .o_ev_ready(w_ev_r), .i_ev(w_ev), .o_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {3'd0, w_res.table_full, w_res.active_count,
                           w_res.fail_cnt, w_res.blocked_now, w_res.allowed};

endmodule

FILE: tb/tb_source_rate_limiter_blocker.sv
// Self-checking testbench of the per-source rate limiter and blocker.
module tb_source_rate_limiter_blocker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         WatchLimit = 5000;
    localparam int         SettleCyc  = 160;
    localparam logic [2:0] RegUnused  = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // source_addr, now_seconds, admin_minutes
    logic [2:0]  s_axis_tuser = '0;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // allowed, blocked_now, failure count,
                                      // active_count, table_full, zero pad
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    source_rate_limiter_blocker dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the source table and the limit registers
    bit          tbl_vld[srl_pkg::TableEntries];
    logic [31:0] tbl_addr[srl_pkg::TableEntries];
    int unsigned tbl_act[srl_pkg::TableEntries], tbl_att[srl_pkg::TableEntries];
    int unsigned tbl_fail[srl_pkg::TableEntries];
    bit          tbl_blk[srl_pkg::TableEntries];
    logic [31:0] tbl_ws[srl_pkg::TableEntries], tbl_be[srl_pkg::TableEntries];
    int unsigned lim_conn = 10, lim_att = 10, lim_fail = 5, base_min = 15;
    bit          prog_on = 1'b1;

    logic [20:0] verdicts[$];
    int          errors = 0, n_events = 0, n_checked = 0, n_full = 0, n_blocked = 0;
    bit          quiet = 1'b0;
    logic [31:0] cur_now = '0;
    logic [31:0] pool[16];

    // Result layout: {table_full, active_count, failures, blocked_now, allowed}
    function automatic logic [20:0] pack_verdict(bit alw, bit bn, int unsigned fl,
                                                 int unsigned act, bit full);
        return {full, 10'(act), 8'(fl), bn, alw};
    endfunction

    // Apply one event to the shadow table and return the verdict it yields
    function automatic logic [20:0] apply_event(srl_pkg::t_func fn, logic [31:0] a,
                                                logic [31:0] tn, logic [15:0] adm);
        int              idx, k;
        bit              keep, full, alw, set_end;
        int unsigned     act, att, fl;
        bit              blk;
        logic [31:0]     ws, be;
        longint unsigned mins, t;
        keep = 0; full = 0; alw = 0; set_end = 0; idx = -1; mins = 0;
        act = 0; att = 0; fl = 0; blk = 0; ws = '0; be = '0;
        // sweep touches every live entry before the lookup
        if (fn == srl_pkg::FN_SWEEP) begin
            for (k = 0; k < srl_pkg::TableEntries; k++) begin
                if (!tbl_vld[k]) continue;
                if (tbl_blk[k] && tn >= tbl_be[k]) begin
                    tbl_blk[k] = 0;
                    tbl_be[k] = '0;
                end
                if (tn >= tbl_ws[k] && tn - tbl_ws[k] > 120) begin
                    tbl_att[k] = 0;
                    tbl_ws[k] = tn;
                end
            end
        end
        for (k = 0; k < srl_pkg::TableEntries; k++)
            if (idx < 0 && tbl_vld[k] && tbl_addr[k] == a) idx = k;
        if (idx >= 0) begin
            keep = 1;
            act = tbl_act[idx]; att = tbl_att[idx]; fl = tbl_fail[idx];
            blk = tbl_blk[idx]; ws = tbl_ws[idx]; be = tbl_be[idx];
        end else if (fn <= srl_pkg::FN_BLOCK) begin
            for (k = 0; k < srl_pkg::TableEntries; k++)
                if (idx < 0 && !tbl_vld[k]) idx = k;
            if (idx >= 0) keep = 1;
            else full = 1;
        end
        case (fn)
            srl_pkg::FN_CONNECT: begin
                if (!(blk && tn < be)) begin
                    if (blk) begin
                        blk = 0;
                        be = '0;
                    end
                    if (act < lim_conn) begin
                        if (tn >= ws && tn - ws >= 60) begin
                            att = 0;
                            ws = tn;
                        end
                        if (att < lim_att) begin
                            if (act < 1023) act++;
                            if (att < 1023) att++;
                            alw = 1;
                        end
                    end
                end
            end
            srl_pkg::FN_AUTHQ: alw = !(blk && tn < be);
            srl_pkg::FN_AFAIL: begin
                if (fl < 255) fl++;
                if (fl >= lim_fail) begin
                    mins = base_min;
                    if (prog_on) begin
                        if (fl > 20) mins = mins * 30;
                        else if (fl > 15) mins = mins * 10;
                        else if (fl > 10) mins = mins * 5;
                        else if (fl > 5) mins = mins * 2;
                    end
                    set_end = 1;
                end
            end
            srl_pkg::FN_AOK: fl = 0;
            srl_pkg::FN_BLOCK: begin
                mins = (adm != 0) ? adm : base_min;
                set_end = 1;
            end
            srl_pkg::FN_UNBLOCK: begin
                if (keep) begin
                    blk = 0;
                    be = '0;
                    fl = 0;
                end
            end
            default: ;
        endcase
        // block end saturates at the top of the time range
        if (set_end) begin
            t = longint'(tn) + mins * 60;
            blk = 1;
            be = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        end
        if (keep) begin
            tbl_vld[idx] = 1; tbl_addr[idx] = a; tbl_act[idx] = act; tbl_att[idx] = att;
            tbl_fail[idx] = fl; tbl_blk[idx] = blk; tbl_ws[idx] = ws; tbl_be[idx] = be;
        end
        return pack_verdict(alw, blk && tn < be, fl, act, full);
    endfunction

    // Result side: random stall bursts, none in the quiet tail
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expected verdict
    always @(posedge i_clk) begin
        logic [20:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = verdicts.pop_front();
                n_checked++;
                if (m_axis_tdata[20:0] !== want) begin
                    errors++;
                    $display("%0t: mismatch exp alw=%0d blk=%0d fail=%0d act=%0d full=%0d",
                             $time, want[0], want[1], want[9:2], want[19:10], want[20]);
                    $display("%0t:          got alw=%0d blk=%0d fail=%0d act=%0d full=%0d",
                             $time, m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[9:2],
                             m_axis_tdata[19:10], m_axis_tdata[20]);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side
    int still_cyc = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            still_cyc = 0;
        else
            still_cyc++;
        if (still_cyc >= WatchLimit) begin
            $display("%0t: watchdog expired, %0d results pending", $time, verdicts.size());
            $display("source_rate_limiter_blocker regression: fail");
            $finish;
        end
    end

    // One register write: setup cycle then access cycle
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            srl_pkg::RegMaxConn: lim_conn = 32'(val[9:0]);
            srl_pkg::RegMaxAtt:  lim_att = 32'(val[9:0]);
            srl_pkg::RegMaxFail: lim_fail = 32'(val[7:0]);
            srl_pkg::RegBlkMin:  base_min = 32'(val[10:0]);
            srl_pkg::RegProg:    prog_on = val[0];
            default: ;
        endcase
    endtask

    task automatic set_limits(int unsigned conn, int unsigned att, int unsigned fl,
                              int unsigned bm, bit pg);
        reg_write(srl_pkg::RegMaxConn, conn);
        reg_write(srl_pkg::RegMaxAtt, att);
        reg_write(srl_pkg::RegMaxFail, fl);
        reg_write(srl_pkg::RegBlkMin, bm);
        reg_write(srl_pkg::RegProg, 32'(pg));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Send one event beat; valid stays up across back-to-back beats
    task automatic send_event(srl_pkg::t_func fn, logic [31:0] a, logic [31:0] tn,
                              logic [15:0] adm, bit typed, logic [20:0] typed_res);
        logic [20:0] p;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {adm, tn, a};
        s_axis_tuser <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
        p = apply_event(fn, a, tn, adm);
        verdicts = {verdicts, (typed ? typed_res : p)};
        n_events++;
        if (p[20]) n_full++;
        if (p[1]) n_blocked++;
    endtask

    // Let every pending result drain and the block go idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (verdicts.size() != 0) @(posedge i_clk);
        repeat (SettleCyc) @(posedge i_clk);
    endtask

    // Mostly known sources and slowly advancing time, some noise
    task automatic random_event();
        srl_pkg::t_func fn;
        logic [31:0]    a;
        logic [15:0]    adm;
        int             r;
        r = $urandom_range(0, 99);
        if (r < 35)      fn = srl_pkg::FN_CONNECT;
        else if (r < 55) fn = srl_pkg::FN_AFAIL;
        else if (r < 63) fn = srl_pkg::FN_AUTHQ;
        else if (r < 70) fn = srl_pkg::FN_AOK;
        else if (r < 77) fn = srl_pkg::FN_BLOCK;
        else if (r < 84) fn = srl_pkg::FN_UNBLOCK;
        else if (r < 90) fn = srl_pkg::FN_SWEEP;
        else             fn = srl_pkg::FN_QUERY;
        a = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 15)] : $urandom;
        r = $urandom_range(0, 99);
        if (r < 2)       cur_now = $urandom;
        else if (r < 8)  cur_now = cur_now + $urandom_range(60, 3000);
        else             cur_now = cur_now + $urandom_range(0, 30);
        r = $urandom_range(0, 3);
        adm = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom) : 16'($urandom_range(1, 5));
        send_event(fn, a, cur_now, adm, 0, '0);
    endtask

    typedef struct {
        srl_pkg::t_func fn;
        logic [31:0]    a;
        logic [31:0]    tn;
        logic [15:0]    adm;
        bit             typed;
        logic [20:0]    res;
    } t_step;

    initial begin
        t_step plan[$];
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 16; k++) pool[k] = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults, plus a write to an unused index that must be ignored
        set_limits(10, 10, 5, 15, 1);
        reg_write(RegUnused, 32'hFFFF_FFFF);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);

        // Directed: lifecycle of one source, then address and time extremes
        plan = {plan, t_step'{srl_pkg::FN_QUERY, 32'h0, 32'd0, 16'd0, 1,
                              pack_verdict(0, 0, 0, 0, 0)}};
        plan = {plan, t_step'{srl_pkg::FN_CONNECT, 32'h0, 32'd0, 16'd0, 1,
                              pack_verdict(1, 0, 0, 1, 0)}};
        plan = {plan, t_step'{srl_pkg::FN_AUTHQ, 32'h0, 32'd5, 16'd0, 1,
                              pack_verdict(1, 0, 0, 1, 0)}};
        repeat (5) plan = {plan, t_step'{srl_pkg::FN_AFAIL, 32'h0, 32'd10, 16'd0, 0, '0}};
        plan = {plan, t_step'{srl_pkg::FN_CONNECT, 32'h0, 32'd20, 16'd0, 1,
                              pack_verdict(0, 1, 5, 1, 0)}};
        plan = {plan, t_step'{srl_pkg::FN_AUTHQ, 32'h0, 32'd21, 16'd0, 1,
                              pack_verdict(0, 1, 5, 1, 0)}};
        plan = {plan, t_step'{srl_pkg::FN_AOK, 32'h0, 32'd25, 16'd0, 0, '0}};
        plan = {plan, t_step'{srl_pkg::FN_UNBLOCK, 32'h0, 32'd26, 16'd0, 0, '0}};
        plan = {plan, t_step'{srl_pkg::FN_BLOCK, 32'h0, 32'd30, 16'd0, 0, '0}};
        plan = {plan, t_step'{srl_pkg::FN_SWEEP, 32'h0, 32'd930, 16'd0, 0, '0}};
        plan = {plan, t_step'{srl_pkg::FN_CONNECT, 32'h0, 32'd931, 16'd0, 0, '0}};
        plan = {plan, t_step'{srl_pkg::FN_UNBLOCK, 32'h1234_5678, 32'd940, 16'd0, 1,
                              pack_verdict(0, 0, 0, 0, 0)}};
        plan = {plan, t_step'{srl_pkg::FN_BLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 16'hFFFF, 1,
                              pack_verdict(0, 1, 0, 0, 0)}};
        plan = {plan, t_step'{srl_pkg::FN_CONNECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 1,
                              pack_verdict(1, 0, 0, 1, 0)}};
        plan = {plan, t_step'{srl_pkg::FN_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 0, '0}};
        plan = {plan, t_step'{srl_pkg::FN_SWEEP, 32'h5555_AAAA, 32'hFFFF_FFFF, 16'd0, 0, '0}};
        plan = {plan, t_step'{srl_pkg::FN_AFAIL, 32'hAAAA_5555, 32'h0000_0100, 16'd0, 0, '0}};
        foreach (plan[k])
            send_event(plan[k].fn, plan[k].a, plan[k].tn, plan[k].adm,
                       plan[k].typed, plan[k].res);
        drain();

        // Tight limits, flat block length of zero minutes
        set_limits(2, 3, 1, 0, 0);
        cur_now = 32'd1000;
        repeat (100) random_event();
        drain();

        // Top limits: failure count runs to saturation through every tier
        set_limits(1023, 1023, 255, 1440, 1);
        for (int k = 0; k < 260; k++)
            send_event(srl_pkg::FN_AFAIL, pool[3], cur_now, 16'd0, 0, '0);
        cur_now = 32'hFFFF_0000;
        repeat (60) random_event();
        drain();

        // Zero limits: every connect refused, every failure blocks
        set_limits(0, 0, 0, 7, 1);
        cur_now = 32'd50_000;
        repeat (40) random_event();
        drain();

        // Mid settings, no idling on either side
        quiet = 1'b1;
        set_limits(5, 4, 3, 2, 1);
        repeat (120) random_event();
        drain();

        $display("Ran %0d events over five limit settings, %0d results checked,",
                 n_events, n_checked);
        $display("%0d with the table full and %0d reporting a live block.",
                 n_full, n_blocked);
        if (errors == 0) begin
            $display("source_rate_limiter_blocker regression: pass");
        end else begin
            $display("source_rate_limiter_blocker regression: fail");
        end
        $finish;
    end
endmodule
